### hdl/seglcd_pkg.sv
package seglcd_pkg;

	// Geometry of the glass.
	localparam int NUM_ROWS    = 4;
	localparam int ROW_WIDTH   = 32;
	localparam int MASK_WIDTH  = 16;
	localparam int FONT_SIZE   = 96;
	localparam int LINE_BITS   = $clog2(ROW_WIDTH);
	localparam int FONT_IDX_W  = $clog2(FONT_SIZE);

	localparam logic [2:0] NUM_DIGITS = 3'd6;
	localparam logic [7:0] SYM_LIMIT  = 8'h60;

	// Request codes.
	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_CLEAR = 1'b1;

	// One input item.
	typedef struct packed {
		logic       req_type;
		logic [2:0] position;
		logic [7:0] symbol;
		logic       clear_first;
	} in_item_t;

	// One result item.
	typedef struct packed {
		logic [31:0] row_com0;
		logic [31:0] row_com1;
		logic [31:0] row_com2;
		logic [31:0] row_com3;
	} out_item_t;

	typedef logic [NUM_ROWS-1:0][ROW_WIDTH-1:0] rows_t;
	typedef logic [3:0][LINE_BITS-1:0] lines_t;

	// Decoded write command handed from the decoder to the row store.
	typedef struct packed {
		logic                  do_write;
		lines_t                lines;
		logic [MASK_WIDTH-1:0] mask;
	} decode_t;

	// Segment masks for codes 0x00 to 0x5F.
	localparam logic [15:0] FONT_MASKS [FONT_SIZE] = '{
		16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
		16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
		16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
		16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
		16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
		16'h0000, 16'h0000, 16'h3FC0, 16'h1540, 16'h0000, 16'h0440, 16'h4000, 16'h2200,
		16'h003F, 16'h0006, 16'h045B, 16'h044F, 16'h0466, 16'h046D, 16'h047D, 16'h2201,
		16'h047F, 16'h046F, 16'h8000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
		16'h0000, 16'h0477, 16'h047C, 16'h0039, 16'h045E, 16'h0479, 16'h0471, 16'h043D,
		16'h0476, 16'h1109, 16'h001E, 16'h1B00, 16'h0038, 16'h02B6, 16'h08B6, 16'h003F,
		16'h0473, 16'h0467, 16'h0C73, 16'h046D, 16'h1101, 16'h003E, 16'h0886, 16'h2836,
		16'h2A80, 16'h1280, 16'h2209, 16'h0000, 16'h0880, 16'h0000, 16'h0000, 16'h0008
	};

	// For each mask bit: the common row it lands in and which of L1..L4 it uses.
	localparam logic [1:0] BIT_ROW [MASK_WIDTH] = '{
		2'd1, 2'd0, 2'd1, 2'd1, 2'd0, 2'd1, 2'd0, 2'd3,
		2'd3, 2'd2, 2'd0, 2'd3, 2'd2, 2'd2, 2'd3, 2'd2
	};
	localparam logic [1:0] BIT_LINE [MASK_WIDTH] = '{
		2'd3, 2'd3, 2'd1, 2'd0, 2'd0, 2'd2, 2'd2, 2'd2,
		2'd3, 2'd3, 2'd1, 2'd0, 2'd0, 2'd2, 2'd1, 2'd1
	};

endpackage

### hdl/ascii_to_segment_lcd_ram_top.sv
// Character encoder for a six-digit 14-segment LCD with four common lines.
// Input channel (in_valid, in_stall, in_item): each item is either a write of
// an ASCII code at a digit position, optionally clearing that digit's segment
// lines first, or a clear of the whole display. Codes 0x60 and above, and
// positions 6 and 7, leave the display as it is.
// Output channel (out_valid, out_stall, out_item): every item yields exactly
// one result, the four 32-bit segment rows after that item's update.
// Latency: an accepted item is registered in the input register; its update is
// applied to the row register, and its result shown valid, when the input
// stage advances, which a result waiting under out_stall can hold back.
// Throughput: one item per cycle while no result waits under out_stall.
// Font lookup and row update: one logic level from input to row register.
// Stalls: while a result waits under out_stall, one more item is taken into
// the input register; only then is in_stall raised.
// Reset (arst_n low) blanks all rows and empties both registers.
module ascii_to_segment_lcd_ram_top
	import seglcd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_item_t  in_item,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_item
);

	in_item_t item_s1;
	logic     valid_s1;
	logic     valid_q;
	logic     advance;
	decode_t  dec;
	rows_t    rows;

	// The input stage moves on whenever the result register is free or being taken.
	assign advance  = valid_s1 && !(valid_q && out_stall);
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_item;
		end
	end

	// Result valid flag; the rows themselves double as the result payload.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	seglcd_decode u_decode (
		.item (item_s1),
		.dec  (dec)
	);

	seglcd_rows u_rows (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (advance),
		.req_type    (item_s1.req_type),
		.clear_first (item_s1.clear_first),
		.dec         (dec),
		.rows        (rows)
	);

	assign out_valid         = valid_q;
	assign out_item.row_com0 = rows[0];
	assign out_item.row_com1 = rows[1];
	assign out_item.row_com2 = rows[2];
	assign out_item.row_com3 = rows[3];

endmodule

### hdl/seglcd_decode.sv
module seglcd_decode
	import seglcd_pkg::*;
(
	input  in_item_t item,
	output decode_t  dec
);

	logic [LINE_BITS-1:0] two_p;
	logic [LINE_BITS-1:0] l1;
	logic [LINE_BITS-1:0] l2;
	logic [LINE_BITS-1:0] base;
	logic                 pos_ok;
	logic                 sym_ok;

	// Segment line positions of the addressed digit.
	always_comb begin
		two_p = {1'b0, item.position, 1'b0};
		l1    = (item.position < 3'd2) ? two_p : two_p + 5'd4;
		l2    = (item.position == 3'd1) ? l1 + 5'd5 : l1 + 5'd1;
		base  = (item.position < 3'd3) ? 5'd29 - two_p : 5'd27 - two_p;
		dec.lines[0] = l1;
		dec.lines[1] = l2;
		if (item.position == 3'd5) begin
			dec.lines[2] = base - 5'd1;
			dec.lines[3] = base;
		end else begin
			dec.lines[2] = base;
			dec.lines[3] = base - 5'd1;
		end
	end

	// Font lookup; codes past the table and digits past the glass write nothing.
	always_comb begin
		pos_ok       = item.position < NUM_DIGITS;
		sym_ok       = item.symbol < SYM_LIMIT;
		dec.mask     = sym_ok ? FONT_MASKS[item.symbol[FONT_IDX_W-1:0]] : '0;
		dec.do_write = (item.req_type == REQ_WRITE) && pos_ok && sym_ok;
	end

endmodule

### hdl/seglcd_rows.sv
module seglcd_rows
	import seglcd_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    en,
	input  logic    req_type,
	input  logic    clear_first,
	input  decode_t dec,
	output rows_t   rows
);

	rows_t                rows_q;
	rows_t                rows_n;
	logic [ROW_WIDTH-1:0] clr;

	// Read-modify-write of the four common rows.
	always_comb begin
		rows_n = rows_q;
		clr    = '0;
		if (req_type == REQ_CLEAR) begin
			rows_n = '0;
		end else if (dec.do_write) begin
			if (clear_first) begin
				for (int k = 0; k < 4; k++) begin
					clr[dec.lines[k]] = 1'b1;
				end
				for (int r = 0; r < NUM_ROWS; r++) begin
					rows_n[r] = rows_n[r] & ~clr;
				end
			end
			for (int i = 0; i < MASK_WIDTH; i++) begin
				if (dec.mask[i]) begin
					rows_n[BIT_ROW[i]][dec.lines[BIT_LINE[i]]] = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= '0;
		end else if (en) begin
			rows_q <= rows_n;
		end
	end

	assign rows = rows_q;

	// A clear request blanks the whole display.
	a_clear_blanks: assert property (@(posedge clk) disable iff (!arst_n)
		en && (req_type == REQ_CLEAR) |=> rows_q == '0)
		else $error("rows not blank after clear request");

	// Rows hold when no item is applied.
	a_hold_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(rows_q))
		else $error("rows changed without an item");

	// A write that has no glyph or no digit leaves the rows alone.
	a_hold_nowrite: assert property (@(posedge clk) disable iff (!arst_n)
		en && (req_type == REQ_WRITE) && !dec.do_write |=> $stable(rows_q))
		else $error("rows changed on an ignored write");

	// Without clear_first a write only ever adds segments.
	a_only_sets: assert property (@(posedge clk) disable iff (!arst_n)
		en && (req_type == REQ_WRITE) && !clear_first
		|=> (rows_q & $past(rows_q)) == $past(rows_q))
		else $error("segment lost on a write without clear_first");

endmodule

### bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
	import seglcd_pkg::*;

	localparam int        RANDOM_ITEMS = 900;
	localparam int        DIR_N        = 23;
	localparam int        CYCLE_LIMIT  = 200000;
	localparam int        SETTLE       = 8;
	localparam out_item_t BLANK        = '0;

	// Font and routing, kept separately from the design's own tables.
	localparam logic [15:0] GLYPH_ROM [96] = '{
		16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
		16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
		16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
		16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
		16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
		16'h0000, 16'h0000, 16'h3FC0, 16'h1540, 16'h0000, 16'h0440, 16'h4000, 16'h2200,
		16'h003F, 16'h0006, 16'h045B, 16'h044F, 16'h0466, 16'h046D, 16'h047D, 16'h2201,
		16'h047F, 16'h046F, 16'h8000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
		16'h0000, 16'h0477, 16'h047C, 16'h0039, 16'h045E, 16'h0479, 16'h0471, 16'h043D,
		16'h0476, 16'h1109, 16'h001E, 16'h1B00, 16'h0038, 16'h02B6, 16'h08B6, 16'h003F,
		16'h0473, 16'h0467, 16'h0C73, 16'h046D, 16'h1101, 16'h003E, 16'h0886, 16'h2836,
		16'h2A80, 16'h1280, 16'h2209, 16'h0000, 16'h0880, 16'h0000, 16'h0000, 16'h0008
	};
	localparam logic [1:0] SEG_ROW [16] = '{
		2'd1, 2'd0, 2'd1, 2'd1, 2'd0, 2'd1, 2'd0, 2'd3,
		2'd3, 2'd2, 2'd0, 2'd3, 2'd2, 2'd2, 2'd3, 2'd2
	};
	localparam logic [1:0] SEG_LINE [16] = '{
		2'd3, 2'd3, 2'd1, 2'd0, 2'd0, 2'd2, 2'd2, 2'd2,
		2'd3, 2'd3, 2'd1, 2'd0, 2'd0, 2'd2, 2'd1, 2'd1
	};

	typedef struct {
		in_item_t  req;
		bit        typed;
		out_item_t want;
	} dir_row_t;

	logic      clk = 1'b0;
	logic      arst_n;
	logic      in_valid;
	logic      in_stall;
	in_item_t  in_item;
	logic      out_valid;
	logic      out_stall;
	out_item_t out_item;

	logic [31:0] glass_rows [4];
	out_item_t   pending_rows [$];
	dir_row_t    dir_tab [DIR_N];
	int          err_count     = 0;
	int          cycle_count   = 0;
	int          items_sent    = 0;
	int          results_seen  = 0;
	int          clears_sent   = 0;
	int          writes_dropped = 0;
	bit          in_burst      = 1'b0;
	bit          out_burst     = 1'b0;

	ascii_to_segment_lcd_ram_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

	always #10 clk = ~clk;

	// Apply one request to the local copy of the segment rows.
	function automatic void update_glass(input in_item_t req);
		int          p;
		int          base;
		int          ln [4];
		logic [31:0] clr;
		logic [15:0] mask;
		if (req.req_type == REQ_CLEAR) begin
			for (int r = 0; r < 4; r++) glass_rows[r] = '0;
		end else if (req.symbol < SYM_LIMIT && req.position < NUM_DIGITS) begin
			p     = int'(req.position);
			ln[0] = (p < 2) ? 2 * p : 2 * p + 4;
			ln[1] = (p == 1) ? ln[0] + 5 : ln[0] + 1;
			base  = (p < 3) ? 29 - 2 * p : 27 - 2 * p;
			ln[2] = (p == 5) ? base - 1 : base;
			ln[3] = (p == 5) ? base : base - 1;
			mask  = GLYPH_ROM[req.symbol];
			if (req.clear_first) begin
				clr = '0;
				for (int k = 0; k < 4; k++) clr[ln[k]] = 1'b1;
				for (int r = 0; r < 4; r++) glass_rows[r] &= ~clr;
			end
			for (int b = 0; b < 16; b++) begin
				if (mask[b]) glass_rows[SEG_ROW[b]][ln[SEG_LINE[b]]] = 1'b1;
			end
		end else begin
			writes_dropped++;
		end
	endfunction

	function automatic out_item_t glass_snapshot();
		out_item_t s;
		s.row_com0 = glass_rows[0];
		s.row_com1 = glass_rows[1];
		s.row_com2 = glass_rows[2];
		s.row_com3 = glass_rows[3];
		return s;
	endfunction

	function automatic dir_row_t drow(input logic rq, input logic [2:0] pos,
		input logic [7:0] sym, input logic cf, input bit typed, input out_item_t want);
		dir_row_t d;
		d.req.req_type    = rq;
		d.req.position    = pos;
		d.req.symbol      = sym;
		d.req.clear_first = cf;
		d.typed           = typed;
		d.want            = want;
		return d;
	endfunction

	// Mostly printable codes at valid positions, with some noise mixed in.
	function automatic in_item_t random_req();
		in_item_t r;
		int       pick;
		r.req_type = ($urandom_range(0, 24) == 0) ? REQ_CLEAR : REQ_WRITE;
		r.position = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(6, 7))
			: 3'($urandom_range(0, 5));
		pick = $urandom_range(0, 9);
		if (pick < 7)
			r.symbol = 8'($urandom_range(32'h20, 32'h5F));
		else if (pick < 8)
			r.symbol = 8'($urandom_range(0, 32'h1F));
		else
			r.symbol = 8'($urandom_range(0, 255));
		r.clear_first = 1'($urandom_range(0, 1));
		return r;
	endfunction

	// Present one item, after a random gap outside bursts, and wait for it to be taken.
	task automatic send_req(input in_item_t req, input bit typed, input out_item_t want);
		int gap;
		gap = in_burst ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_item  <= req;
		do @(posedge clk); while (in_stall);
		update_glass(req);
		if (req.req_type == REQ_CLEAR) clears_sent++;
		pending_rows.push_back(typed ? want : glass_snapshot());
		items_sent++;
		if (items_sent % 40 == 0) in_burst = ($urandom_range(0, 3) == 0);
	endtask

	task automatic check_row(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %h, got %h", name, want, got);
			err_count++;
		end
	endtask

	// Result sink: random stall before each result outside bursts.
	initial begin : result_sink
		int hold;
		out_stall <= 1'b0;
		forever begin
			hold = out_burst ? 0 : $urandom_range(0, 9);
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
				out_stall <= 1'b0;
			end
			do @(posedge clk); while (!(arst_n && out_valid));
			if ($urandom_range(0, 39) == 0) out_burst = ($urandom_range(0, 3) == 0);
		end
	end

	// Compare each accepted result with the oldest expected rows.
	always @(posedge clk) begin
		out_item_t exp_rows;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (pending_rows.size() == 0) begin
				$error("unexpected result: rows %h", out_item);
				err_count++;
			end else begin
				exp_rows = pending_rows.pop_front();
				check_row("row_com0", exp_rows.row_com0, out_item.row_com0);
				check_row("row_com1", exp_rows.row_com1, out_item.row_com1);
				check_row("row_com2", exp_rows.row_com2, out_item.row_com2);
				check_row("row_com3", exp_rows.row_com3, out_item.row_com3);
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_top: done, errors");
			$finish;
		end
	end

	initial begin : stimulus
		in_item_t req;
		arst_n   <= 1'b0;
		in_valid <= 1'b0;
		in_item  <= '0;
		for (int r = 0; r < 4; r++) glass_rows[r] = '0;

		// Directed rows: blank display cases, extremes of position and code,
		// the widest masks and the codes without a mask.
		dir_tab = '{
			drow(REQ_CLEAR, 3'd0, 8'h00, 1'b0, 1'b1, BLANK),
			drow(REQ_WRITE, 3'd0, 8'h7F, 1'b0, 1'b1, BLANK),
			drow(REQ_WRITE, 3'd6, 8'h38, 1'b1, 1'b1, BLANK),
			drow(REQ_WRITE, 3'd7, 8'hFF, 1'b1, 1'b1, BLANK),
			drow(REQ_WRITE, 3'd0, 8'h38, 1'b0, 1'b1,
				{32'h3000_0003, 32'h3000_0003, 32'h0, 32'h0}),
			drow(REQ_WRITE, 3'd1, 8'h41, 1'b0, 1'b0, BLANK),
			drow(REQ_WRITE, 3'd2, 8'h2A, 1'b0, 1'b0, BLANK),
			drow(REQ_WRITE, 3'd3, 8'h57, 1'b1, 1'b0, BLANK),
			drow(REQ_WRITE, 3'd4, 8'h58, 1'b0, 1'b0, BLANK),
			drow(REQ_WRITE, 3'd5, 8'h32, 1'b1, 1'b0, BLANK),
			drow(REQ_WRITE, 3'd5, 8'h60, 1'b1, 1'b0, BLANK),
			drow(REQ_WRITE, 3'd0, 8'h00, 1'b1, 1'b0, BLANK),
			drow(REQ_WRITE, 3'd3, 8'h5F, 1'b1, 1'b0, BLANK),
			drow(REQ_WRITE, 3'd2, 8'h3A, 1'b0, 1'b0, BLANK),
			drow(REQ_WRITE, 3'd1, 8'h2E, 1'b1, 1'b0, BLANK),
			drow(REQ_WRITE, 3'd4, 8'h5F, 1'b0, 1'b0, BLANK),
			drow(REQ_WRITE, 3'd5, 8'h4D, 1'b1, 1'b0, BLANK),
			drow(REQ_WRITE, 3'd0, 8'h3A, 1'b1, 1'b0, BLANK),
			drow(REQ_CLEAR, 3'd7, 8'hFF, 1'b1, 1'b1, BLANK),
			drow(REQ_WRITE, 3'd5, 8'hFF, 1'b0, 1'b1, BLANK),
			drow(REQ_WRITE, 3'd5, 8'h2A, 1'b0, 1'b0, BLANK),
			drow(REQ_WRITE, 3'd4, 8'h2A, 1'b1, 1'b0, BLANK),
			drow(REQ_WRITE, 3'd3, 8'h5E, 1'b1, 1'b0, BLANK)
		};

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < DIR_N; i++)
			send_req(dir_tab[i].req, dir_tab[i].typed, dir_tab[i].want);

		// Random part, checked against the local copy of the rows.
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			req = random_req();
			send_req(req, 1'b0, BLANK);
		end
		in_valid <= 1'b0;

		while (pending_rows.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);

		$display("tb_top: %0d items sent, %0d clears, %0d writes without effect",
			items_sent, clears_sent, writes_dropped);
		$display("tb_top: %0d result rows compared, %0d mismatches", results_seen, err_count);
		if (err_count == 0 && pending_rows.size() == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule

### ascii_to_segment_lcd_ram_top.f
hdl/seglcd_pkg.sv
hdl/seglcd_decode.sv
hdl/seglcd_rows.sv
hdl/ascii_to_segment_lcd_ram_top.sv
bench/tb_top.sv
